// ----- sv/bus_trace_recorder_with_trigger_defines.svh -----
// Assertion macros for the bus trace recorder.
// Used by bus_trace_recorder_with_trigger.sv; expects clk and rst_n in scope.
`ifndef BUS_TRACE_RECORDER_WITH_TRIGGER_DEFINES_SVH
`define BUS_TRACE_RECORDER_WITH_TRIGGER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/btr_pkg.sv -----
// Shared types and constants for the bus trace recorder.
// No dependencies; used by bus_trace_recorder_with_trigger.sv.
`default_nettype none

package btr_pkg;

  localparam int unsigned CYCLE_W  = 64;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IN_DW    = 104;
  localparam int unsigned OUT_DW   = 96;

  // Register indexes on the configuration port
  localparam logic REG_TRIGGER = 1'b0;
  localparam logic REG_DEPTH   = 1'b1;

  // Request kinds carried on in_tuser
  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_DISABLE = 1'b1;

  localparam logic [ADDR_W-1:0]  TRIGGER_RST = 16'h0000;
  localparam logic [DEPTH_W-1:0] DEPTH_RST   = 7'd64;

  // One stored sample; bit layout matches out_tdata from bit 0 up
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [ADDR_W-1:0] address;
    logic [CYCLE_W-1:0] cycle;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_REC  = 3'b001,
    ST_DUMP = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ----- sv/bus_trace_recorder_with_trigger.sv -----
// Bus trace recorder with address trigger: history memory, dump sequencer, stream ports.
// Depends on btr_pkg.sv and bus_trace_recorder_with_trigger_defines.svh.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  in_     | in  | tvalid / tready  | tdata: sample fields, tuser: mode
//  out_    | out | tvalid / tready  | tdata: recorded entry, tlast: newest entry
//  cfg_    | in  | we               | index 0 trigger address, 1 kept depth
//
// Cycles: while recording, one sample request is taken every cycle (one memory write).
// A trigger hit stalls the input for the dump: the kept entries leave one per cycle
// while out_tready is high, each read out through the registered memory read port.
// After a trigger or a disable request, requests are taken and dropped until reset.
// Reset (rst_n low, synchronous) clears the pointers and the state; the history memory
// is not cleared, since only entries written since the last clear are ever read.
`default_nettype none

module bus_trace_recorder_with_trigger #(
  parameter int unsigned MAX_HISTORY = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // cycle_count[63:0], bus_address[79:64], read_not_write[80],
  // read_byte[88:81], write_byte[96:89], zero fill [103:97]
  input  wire logic [btr_pkg::IN_DW-1:0]    in_tdata,
  // mode[0]
  input  wire logic                         in_tuser,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  // rec_cycle[63:0], rec_address[79:64], rec_data[87:80], rec_read[88], zero fill [95:89]
  output      logic [btr_pkg::OUT_DW-1:0]   out_tdata,
  output      logic                         out_tlast,
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [btr_pkg::CFG_W-1:0]    cfg_wdata
);

`include "bus_trace_recorder_with_trigger_defines.svh"

  localparam int unsigned AW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
  localparam int unsigned CW = $clog2(MAX_HISTORY + 1);
  localparam int unsigned DW = (CW > btr_pkg::DEPTH_W) ? CW : btr_pkg::DEPTH_W;
  localparam int unsigned SW = CW + 1;

  // Configuration registers
  logic [btr_pkg::ADDR_W-1:0]  trigger_r;
  logic [btr_pkg::DEPTH_W-1:0] depth_r;

  // Control state
  btr_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last_r;

  // History memory, one entry per sample, registered read port
  btr_pkg::entry_t hist_mem [MAX_HISTORY];
  btr_pkg::entry_t rdata_r;

  // Unpacked request fields
  logic                       in_acc;
  logic                       is_sample;
  logic [btr_pkg::ADDR_W-1:0] s_addr;
  logic                       s_read;
  btr_pkg::entry_t            wr_entry;
  logic                       mem_we;
  logic                       rd_en;
  logic                       hit;

  logic [CW-1:0] eff_depth;
  logic [DW-1:0] depth_ext;
  logic [CW-1:0] count_inc;
  logic [AW-1:0] wp_inc;
  logic [SW-1:0] wp_wide;
  logic [SW-1:0] cnt_wide;
  logic [SW-1:0] first_wide;

  assign in_acc    = in_tvalid && in_tready;
  assign is_sample = (in_tuser == btr_pkg::MODE_SAMPLE);
  assign s_addr    = in_tdata[79:64];
  assign s_read    = in_tdata[80];

  assign wr_entry.cycle   = in_tdata[63:0];
  assign wr_entry.address = s_addr;
  assign wr_entry.data    = s_read ? in_tdata[88:81] : in_tdata[96:89];
  assign wr_entry.kind    = s_read;

  // Take requests while recording or after the recorder went inactive; stall during a dump
  assign in_tready = (state_r != btr_pkg::ST_DUMP);

  assign mem_we = in_acc && is_sample && (state_r == btr_pkg::ST_REC);
  assign hit    = (s_addr == trigger_r);

  // Clamp the depth register to 1..MAX_HISTORY
  always_comb begin
    depth_ext = DW'(depth_r);
    if (depth_r == '0) begin
      eff_depth = CW'(1);
    end else if (depth_ext > DW'(MAX_HISTORY)) begin
      eff_depth = CW'(MAX_HISTORY);
    end else begin
      eff_depth = depth_ext[CW-1:0];
    end
  end

  // Count after a recorded sample: grow up to the depth, trim to it when it shrank
  assign count_inc = (count_r < eff_depth) ? count_r + CW'(1) : eff_depth;

  assign wp_inc = (wp_r == AW'(MAX_HISTORY - 1)) ? '0 : wp_r + AW'(1);

  // Oldest entry after this write: write position minus count, modulo the memory depth
  assign wp_wide  = SW'(wp_inc);
  assign cnt_wide = SW'(count_inc);
  always_comb begin
    if (wp_wide >= cnt_wide) begin
      first_wide = wp_wide - cnt_wide;
    end else begin
      first_wide = wp_wide + SW'(MAX_HISTORY) - cnt_wide;
    end
  end

  // Issue a read whenever the output register is free or being emptied this cycle
  assign rd_en = (state_r == btr_pkg::ST_DUMP) && (rem_r != '0) &&
                 (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Sample path: advance the write position and grow the count up to the depth
    if (mem_we) begin
      wp_nxt    = wp_inc;
      count_nxt = count_inc;
    end

    case (state_r)
      btr_pkg::ST_REC: begin
        if (in_acc && !is_sample) begin
          // Disable: drop the history and stop for good
          wp_nxt    = '0;
          count_nxt = '0;
          state_nxt = btr_pkg::ST_DONE;
        end else if (mem_we && hit) begin
          rd_ptr_nxt = first_wide[AW-1:0];
          rem_nxt    = count_inc;
          state_nxt  = btr_pkg::ST_DUMP;
        end
      end
      btr_pkg::ST_DUMP: begin
        if (rd_en) begin
          rd_ptr_nxt    = (rd_ptr_r == AW'(MAX_HISTORY - 1)) ? '0 : rd_ptr_r + AW'(1);
          rem_nxt       = rem_r - CW'(1);
          out_valid_nxt = 1'b1;
        end else if (rem_r == '0 && (!out_valid_r || out_tready)) begin
          state_nxt = btr_pkg::ST_DONE;
        end
      end
      btr_pkg::ST_DONE: begin
        if (in_acc && !is_sample) begin
          wp_nxt    = '0;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = btr_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btr_pkg::ST_REC;
      wp_r        <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      trigger_r   <= btr_pkg::TRIGGER_RST;
      depth_r     <= btr_pkg::DEPTH_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          btr_pkg::REG_TRIGGER: trigger_r <= cfg_wdata[btr_pkg::ADDR_W-1:0];
          btr_pkg::REG_DEPTH:   depth_r   <= cfg_wdata[btr_pkg::DEPTH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Memory write and registered read; the read data doubles as the output register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[wp_r] <= wr_entry;
    end
    if (rd_en) begin
      rdata_r <= hist_mem[rd_ptr_r];
      last_r  <= (rem_r == CW'(1));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(btr_pkg::OUT_DW - btr_pkg::ENTRY_W)'(0), rdata_r};
  assign out_tlast  = last_r;

  `BTR_ASSERT_NOW(a_out_only_in_dump, out_valid_r, state_r == btr_pkg::ST_DUMP, "result outside dump")
  `BTR_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_HISTORY), "entry count beyond memory depth")
  `BTR_ASSERT_NOW(a_last_at_end, out_valid_r && last_r, rem_r == '0, "last marker before dump end")
  `BTR_ASSERT_NEXT(a_read_lands, rd_en, out_valid_r, "memory read did not reach output")

endmodule

`default_nettype wire
